// File: hw/rtl/sample_window_autoscale_assert.svh
// ---------------------------------------------------------------------------
// sample_window_autoscale assertion macros
// concurrent checks, compiled out for synthesis
// ---------------------------------------------------------------------------
`ifndef SAMPLE_WINDOW_AUTOSCALE_ASSERT_SVH
`define SAMPLE_WINDOW_AUTOSCALE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SWA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SWA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SWA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define SWA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: hw/rtl/swa_pkg.sv
// ---------------------------------------------------------------------------
// swa_pkg
// shared widths, codes, control bundles and the axis ladder
// ---------------------------------------------------------------------------
`default_nettype none

package swa_pkg;

  localparam int unsigned DEPTH_DEF  = 64;

  localparam int unsigned CMD_W      = 2;
  localparam int unsigned SAMPLE_W   = 48;
  localparam int unsigned INDEX_W    = 6;
  localparam int unsigned WIN_W      = 47;
  localparam int unsigned AXIS_W     = 32;
  localparam int unsigned TOTAL_W    = 32;
  localparam int unsigned FILL_W     = 7;
  localparam int unsigned RUNG_W     = 4;
  localparam int unsigned RUNGS      = 10;

  // three-entry sum width and the step count of its divide by three
  localparam int unsigned SUM_W      = WIN_W + 2;
  localparam int unsigned DIV_STEPS  = 3;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS + 1);

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // register index, taken from the word address
  localparam logic REG_PINNED = 1'b0;

  localparam logic [AXIS_W-1:0] PINNED_AXIS = 32'd100;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH    = 2'd0,
    CMD_READ    = 2'd1,
    CMD_RESCALE = 2'd2
  } swa_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_CMP,
    ST_SEL,
    ST_DONE
  } swa_state_t;

  typedef struct packed {
    logic shift_in;
    logic rotate;
  } swa_chain_ctl_t;

  typedef struct packed {
    logic load;
    logic run;
  } swa_div_ctl_t;

  function automatic logic [AXIS_W-1:0] ladder(input logic [RUNG_W-1:0] rung);
    logic [AXIS_W-1:0] val;
    case (rung)
      4'd0:    val = 32'd16000;
      4'd1:    val = 32'd64000;
      4'd2:    val = 32'd256000;
      4'd3:    val = 32'd1000000;
      4'd4:    val = 32'd4000000;
      4'd5:    val = 32'd16000000;
      4'd6:    val = 32'd64000000;
      4'd7:    val = 32'd256000000;
      4'd8:    val = 32'd1000000000;
      4'd9:    val = 32'd4000000000;
      default: val = 32'd16000;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/swa_in_if.sv
// ---------------------------------------------------------------------------
// swa_in_if
// request channel: command, sample and read index
// ---------------------------------------------------------------------------
`default_nettype none

interface swa_in_if import swa_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [CMD_W-1:0]           command;
  logic signed [SAMPLE_W-1:0] sample;
  logic [INDEX_W-1:0]         index;

  modport source (output valid, command, sample, index, input ready);
  modport sink   (input valid, command, sample, index, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/swa_out_if.sv
// ---------------------------------------------------------------------------
// swa_out_if
// result channel: entry, mean, axis, sample number and fill
// ---------------------------------------------------------------------------
`default_nettype none

interface swa_out_if import swa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [WIN_W-1:0]    raw_value;
  logic [WIN_W-1:0]    smoothed_value;
  logic [AXIS_W-1:0]   axis_scale;
  logic [TOTAL_W-1:0]  sample_number;
  logic [FILL_W-1:0]   fill_count;

  modport source (
    output valid, raw_value, smoothed_value, axis_scale, sample_number, fill_count,
    input  ready
  );
  modport sink (
    input  valid, raw_value, smoothed_value, axis_scale, sample_number, fill_count,
    output ready
  );
endinterface

`default_nettype wire

// File: hw/rtl/sample_window_autoscale.sv
// ---------------------------------------------------------------------------
// sample_window_autoscale
// push: goes straight to done to register its result; unused command likewise
// read: ring turn, then divide for a middle entry, then done; past fill: done
// rescale: ring turn for the peak, compare, select, then done; pinned: done
// next request is taken as soon as the result is registered
// rst_n is synchronous; control, fill, count, rung and mode clear at once
// window cells are not cleared: entries beyond the fill are never read
// ---------------------------------------------------------------------------
`default_nettype none

`include "sample_window_autoscale_assert.svh"

module sample_window_autoscale
  import swa_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  swa_in_if.sink                in_req,
  swa_out_if.source             out_res,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int unsigned      POS_W    = $clog2(DEPTH);
  localparam int unsigned      CNT_W    = $clog2(DEPTH + 1);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  // -------------------------------------------------------------------------
  // state
  // -------------------------------------------------------------------------
  swa_state_t          state_r;
  swa_state_t          state_nxt;
  logic [POS_W-1:0]    step_r;
  logic [POS_W-1:0]    step_nxt;
  logic [CNT_W-1:0]    held_r;
  logic [CNT_W-1:0]    held_nxt;
  logic [TOTAL_W-1:0]  total_r;
  logic [TOTAL_W-1:0]  total_nxt;
  logic [RUNG_W-1:0]   rung_r;
  logic [RUNG_W-1:0]   rung_nxt;
  logic                pinned_r;
  logic                pinned_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;

  // request context, held for the duration of the request
  swa_cmd_t            cmd_r;
  logic                hit_r;
  logic                edge_r;
  logic [POS_W-1:0]    tgt_r;

  // datapath
  logic [WIN_W-1:0]    raw_r;
  logic [WIN_W-1:0]    peak_r;
  logic [RUNGS-1:0]    gt_r;
  logic                over_r;
  logic                under_r;

  logic [WIN_W-1:0]    res_raw_r;
  logic [WIN_W-1:0]    res_smooth_r;
  logic [AXIS_W-1:0]   res_axis_r;
  logic [TOTAL_W-1:0]  res_total_r;
  logic [FILL_W-1:0]   res_fill_r;

  // -------------------------------------------------------------------------
  // handshakes and request decode
  // -------------------------------------------------------------------------
  logic                in_fire;
  logic                out_load;
  logic                cfg_wr;
  logic [WIN_W-1:0]    push_data;
  logic [31:0]         idx_w;
  logic [31:0]         held_w;
  logic [31:0]         rd_pos;
  logic                rd_hit;
  logic                rd_edge;
  logic [POS_W-1:0]    rd_tgt;

  swa_chain_ctl_t      chain_ctl;
  swa_div_ctl_t        div_ctl;
  logic [WIN_W-1:0]    tap0;
  logic [WIN_W-1:0]    tap1;
  logic [WIN_W-1:0]    tap2;
  logic [WIN_W-1:0]    quotient;
  logic                div_done;
  logic                scan_valid;

  assign in_fire = in_req.valid && in_req.ready;
  assign cfg_wr  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // negative samples are clamped to zero
  assign push_data = in_req.sample[SAMPLE_W-1] ? '0 : in_req.sample[WIN_W-1:0];

  // logical index 0 is the oldest entry; cell 0 holds the newest, so the
  // entry sits in cell held-1-index. the scan captures when the cell just
  // before it reaches tap0, i.e. after (cell - 1) mod DEPTH rotations
  assign idx_w   = 32'(in_req.index);
  assign held_w  = 32'(held_r);
  assign rd_hit  = (idx_w < held_w);
  assign rd_pos  = held_w - idx_w - 32'd1;
  assign rd_edge = (held_w < 32'd3) || (idx_w == 32'd0) || (rd_pos == 32'd0);
  assign rd_tgt  = (rd_pos == 32'd0) ? LAST_POS : POS_W'(rd_pos - 32'd1);

  // during a scan, tap0 shows the cell originally at position step_r
  assign scan_valid = (32'(step_r) < held_w);

  // -------------------------------------------------------------------------
  // sequencer: next state
  // -------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_req.command)
            CMD_PUSH:    state_nxt = ST_DONE;
            CMD_READ:    state_nxt = rd_hit ? ST_SCAN : ST_DONE;
            CMD_RESCALE: state_nxt = pinned_r ? ST_DONE : ST_SCAN;
            default:     state_nxt = ST_DONE;
          endcase
        end
      end
      ST_SCAN: begin
        if (step_r == LAST_POS) begin
          if (cmd_r == CMD_READ) begin
            // ends and short windows report the entry itself, no mean needed
            state_nxt = edge_r ? ST_DONE : ST_DIV;
          end else begin
            state_nxt = ST_CMP;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_CMP:  state_nxt = ST_SEL;
      ST_SEL:  state_nxt = ST_DONE;
      ST_DONE: begin
        if (!out_valid_r || out_res.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // -------------------------------------------------------------------------
  // sequencer: outputs
  // -------------------------------------------------------------------------
  always_comb begin
    in_req.ready       = (state_r == ST_IDLE);
    chain_ctl.shift_in = 1'b0;
    chain_ctl.rotate   = 1'b0;
    div_ctl.load       = 1'b0;
    div_ctl.run        = 1'b0;
    out_load           = 1'b0;
    case (state_r)
      ST_IDLE: begin
        // ready is high throughout idle
        chain_ctl.shift_in = in_req.valid && (in_req.command == CMD_PUSH);
      end
      ST_SCAN: begin
        // one full turn of the ring leaves every cell where it started
        chain_ctl.rotate = 1'b1;
        div_ctl.load     = (cmd_r == CMD_READ) && (step_r == tgt_r);
      end
      ST_DIV: begin
        div_ctl.run = 1'b1;
      end
      ST_DONE: begin
        out_load = !out_valid_r || out_res.ready;
      end
      default: ;
    endcase
  end

  // -------------------------------------------------------------------------
  // fill count, sample number, scan step, mode, result valid
  // -------------------------------------------------------------------------
  always_comb begin
    held_nxt  = held_r;
    total_nxt = total_r;
    if (chain_ctl.shift_in) begin
      // once full, the oldest entry falls off the far end of the chain
      if (held_r != FULL_CNT) begin
        held_nxt = held_r + CNT_W'(1);
      end
      total_nxt = total_r + TOTAL_W'(1);
    end
  end

  always_comb begin
    step_nxt = step_r;
    if (in_fire) begin
      step_nxt = '0;
    end else if (state_r == ST_SCAN) begin
      step_nxt = step_r + POS_W'(1);
    end
  end

  always_comb begin
    pinned_nxt = pinned_r;
    if (cfg_wr && (cfg_paddr[CFG_ADDR_W-1:2] == REG_PINNED)) begin
      pinned_nxt = cfg_pwdata[0];
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_res.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // -------------------------------------------------------------------------
  // axis ladder with hysteresis
  // grow: lowest rung above the peak, else the top rung
  // shrink (3*peak below axis): the rung just below, if still above the peak,
  // else the bottom rung; gt_r is monotonic so one lookup settles it
  // -------------------------------------------------------------------------
  always_comb begin
    rung_nxt = rung_r;
    if (state_r == ST_SEL) begin
      if (over_r) begin
        rung_nxt = RUNG_W'(RUNGS - 1);
        for (int i = RUNGS - 1; i >= 0; i--) begin
          if (gt_r[i]) begin
            rung_nxt = RUNG_W'(i);
          end
        end
      end else if (under_r) begin
        if ((rung_r != '0) && gt_r[rung_r - RUNG_W'(1)]) begin
          rung_nxt = rung_r - RUNG_W'(1);
        end else begin
          rung_nxt = '0;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // control registers
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      held_r      <= '0;
      total_r     <= '0;
      rung_r      <= '0;
      pinned_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      held_r      <= held_nxt;
      total_r     <= total_nxt;
      rung_r      <= rung_nxt;
      pinned_r    <= pinned_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // -------------------------------------------------------------------------
  // request context and datapath registers
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r  <= swa_cmd_t'(in_req.command);
      hit_r  <= rd_hit;
      edge_r <= rd_edge;
      tgt_r  <= rd_tgt;
    end
  end

  // tap1 is the addressed entry when its newer neighbour has reached tap0
  always_ff @(posedge clk) begin
    if (div_ctl.load) begin
      raw_r <= tap1;
    end
  end

  // running peak over the filled cells as they pass tap0
  always_ff @(posedge clk) begin
    if (in_fire) begin
      peak_r <= '0;
    end else if ((state_r == ST_SCAN) && (cmd_r == CMD_RESCALE) && scan_valid &&
                 (tap0 > peak_r)) begin
      peak_r <= tap0;
    end
  end

  // ladder compares, registered ahead of the rung choice
  always_ff @(posedge clk) begin
    if (state_r == ST_CMP) begin
      for (int i = 0; i < RUNGS; i++) begin
        gt_r[i] <= (WIN_W'(ladder(RUNG_W'(i))) > peak_r);
      end
      over_r  <= (peak_r > WIN_W'(ladder(rung_r)));
      under_r <= (({2'b00, peak_r} + {1'b0, peak_r, 1'b0}) < SUM_W'(ladder(rung_r)));
    end
  end

  // result register: frees the sequencer while the result waits downstream
  always_ff @(posedge clk) begin
    if (out_load) begin
      res_raw_r    <= '0;
      res_smooth_r <= '0;
      if ((cmd_r == CMD_READ) && hit_r) begin
        res_raw_r    <= raw_r;
        res_smooth_r <= edge_r ? raw_r : quotient;
      end
      res_axis_r  <= pinned_r ? PINNED_AXIS : ladder(rung_r);
      res_total_r <= total_r;
      res_fill_r  <= FILL_W'(held_r);
    end
  end

  assign out_res.valid          = out_valid_r;
  assign out_res.raw_value      = res_raw_r;
  assign out_res.smoothed_value = res_smooth_r;
  assign out_res.axis_scale     = res_axis_r;
  assign out_res.sample_number  = res_total_r;
  assign out_res.fill_count     = res_fill_r;

  // -------------------------------------------------------------------------
  // configuration port
  // -------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[CFG_ADDR_W-1:2] == REG_PINNED) ?
                      {{(CFG_DATA_W-1){1'b0}}, pinned_r} : '0;

  // -------------------------------------------------------------------------
  // window chain and divider
  // -------------------------------------------------------------------------
  swa_chain #(
    .DEPTH (DEPTH)
  ) u_chain (
    .clk       (clk),
    .ctl       (chain_ctl),
    .push_data (push_data),
    .tap0      (tap0),
    .tap1      (tap1),
    .tap2      (tap2)
  );

  // sum of the entry and both neighbours, taken at the capture step
  swa_div3 u_div3 (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend ({2'b00, tap0} + {2'b00, tap1} + {2'b00, tap2}),
    .quotient (quotient),
    .done     (div_done)
  );

  // -------------------------------------------------------------------------
  // assertions
  // -------------------------------------------------------------------------
  `SWA_ASSERT_IMP(a_rung_range, clk, rst_n, 1'b1, rung_r < RUNG_W'(RUNGS), "axis rung beyond ladder")
  `SWA_ASSERT_IMP(a_fill_bound, clk, rst_n, 1'b1, held_r <= FULL_CNT, "fill count beyond depth")
  `SWA_ASSERT_NXT(a_push_fill, clk, rst_n, in_fire && (in_req.command == CMD_PUSH) && (held_r != FULL_CNT), held_r == $past(held_r) + CNT_W'(1), "push did not grow fill")
  `SWA_ASSERT_NXT(a_pinned_rung, clk, rst_n, pinned_r, $stable(rung_r), "rung moved while pinned")
  `SWA_ASSERT_NXT(a_scan_turn, clk, rst_n, (state_r == ST_SCAN) && (step_r == LAST_POS), state_r != ST_SCAN, "scan ran past one ring turn")

endmodule

`default_nettype wire

// File: hw/rtl/swa_cell.sv
// ---------------------------------------------------------------------------
// swa_cell
// one window entry: loads from the newer side on push, the older side on rotate
// ---------------------------------------------------------------------------
`default_nettype none

module swa_cell
  import swa_pkg::*;
(
  input  logic             clk,
  input  swa_chain_ctl_t   ctl,
  input  logic [WIN_W-1:0] from_prev,
  input  logic [WIN_W-1:0] from_next,
  output logic [WIN_W-1:0] q
);

  logic [WIN_W-1:0] val_r;
  logic [WIN_W-1:0] val_nxt;

  always_comb begin
    val_nxt = val_r;
    if (ctl.shift_in) begin
      val_nxt = from_prev;
    end else if (ctl.rotate) begin
      val_nxt = from_next;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign q = val_r;

endmodule

`default_nettype wire

// File: hw/rtl/swa_chain.sv
// ---------------------------------------------------------------------------
// swa_chain
// row of window cells, newest at cell 0, closed into a ring for scans
// ---------------------------------------------------------------------------
`default_nettype none

module swa_chain
  import swa_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic             clk,
  input  swa_chain_ctl_t   ctl,
  input  logic [WIN_W-1:0] push_data,
  output logic [WIN_W-1:0] tap0,
  output logic [WIN_W-1:0] tap1,
  output logic [WIN_W-1:0] tap2
);

  logic [WIN_W-1:0] cell_q [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [WIN_W-1:0] from_prev;
    logic [WIN_W-1:0] from_next;

    if (k == 0) begin : g_head
      assign from_prev = push_data;
    end else begin : g_body
      assign from_prev = cell_q[k-1];
    end

    // last cell closes the ring back to the head
    assign from_next = cell_q[(k + 1) % DEPTH];

    swa_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .from_prev (from_prev),
      .from_next (from_next),
      .q         (cell_q[k])
    );
  end

  assign tap0 = cell_q[0];
  assign tap1 = cell_q[1];
  assign tap2 = cell_q[2];

endmodule

`default_nettype wire

// File: hw/rtl/swa_div3.sv
// ---------------------------------------------------------------------------
// swa_div3
// divide by three in three registered steps: split, reciprocal, combine
// ---------------------------------------------------------------------------
`default_nettype none

module swa_div3
  import swa_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  swa_div_ctl_t     ctl,
  input  logic [SUM_W-1:0] dividend,
  output logic [WIN_W-1:0] quotient,
  output logic             done
);

  // 2^24 = 3 * K_HI + 1, so n / 3 = hi * K_HI + (hi + lo) / 3
  localparam int unsigned LO_W   = 24;
  localparam int unsigned HI_W   = SUM_W - LO_W;
  localparam int unsigned MID_W  = HI_W + 1;
  localparam int unsigned K_W    = 23;
  localparam int unsigned HP_W   = HI_W + K_W;
  localparam int unsigned MP_W   = MID_W + MID_W;
  localparam int unsigned RCP_SH = MID_W + 1;

  localparam logic [K_W-1:0]   K_HI = 23'd5592405;
  // ceil(2^27 / 3): exact floor for any middle sum below 2^26
  localparam logic [MID_W-1:0] RCP  = 26'd44739243;

  localparam logic [DIV_CNT_W-1:0] STEP_SPLIT = DIV_CNT_W'(0);
  localparam logic [DIV_CNT_W-1:0] STEP_RCP   = DIV_CNT_W'(1);

  logic [SUM_W-1:0]     n_r;
  logic [SUM_W-1:0]     n_nxt;
  logic [HP_W-1:0]      hp_r;
  logic [HP_W-1:0]      hp_nxt;
  logic [MID_W-1:0]     mid_r;
  logic [MID_W-1:0]     mid_nxt;
  logic [MP_W-1:0]      mp_r;
  logic [MP_W-1:0]      mp_nxt;
  logic [WIN_W-1:0]     q_r;
  logic [WIN_W-1:0]     q_nxt;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_CNT_W-1:0] cnt_nxt;
  logic [HI_W-1:0]      hi;
  logic [LO_W-1:0]      lo;

  assign done = (cnt_r == DIV_CNT_W'(DIV_STEPS));

  always_comb begin
    hi      = n_r[SUM_W-1:LO_W];
    lo      = n_r[LO_W-1:0];
    n_nxt   = n_r;
    hp_nxt  = hp_r;
    mid_nxt = mid_r;
    mp_nxt  = mp_r;
    q_nxt   = q_r;
    cnt_nxt = cnt_r;
    if (ctl.load) begin
      n_nxt   = dividend;
      cnt_nxt = '0;
    end else if (ctl.run && !done) begin
      cnt_nxt = cnt_r + DIV_CNT_W'(1);
      case (cnt_r)
        STEP_SPLIT: begin
          hp_nxt  = HP_W'(hi) * HP_W'(K_HI);
          mid_nxt = MID_W'(hi) + MID_W'(lo);
        end
        STEP_RCP: begin
          mp_nxt = MP_W'(mid_r) * MP_W'(RCP);
        end
        default: begin
          q_nxt = WIN_W'(hp_r + HP_W'(mp_r >> RCP_SH));
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    hp_r  <= hp_nxt;
    mid_r <= mid_nxt;
    mp_r  <= mp_nxt;
    q_r   <= q_nxt;
  end

  // quotient of a three-entry sum always fits an entry
  assign quotient = q_r;

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for sample_window_autoscale: a directed opening, then
// random sample episodes whose magnitudes are mostly capped, the caps mostly near the axis ladder boundaries,
// run with autoscale, pinned and autoscale again, under random idling on both
// channels; every result is checked against a local window/axis predictor
// ---------------------------------------------------------------------------
module tb_top;
  import swa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // depth of the window as built, and the code with no command behind it
  localparam int unsigned                 WINDOW_DEPTH = DEPTH_DEF;
  localparam logic [CMD_W-1:0]            CMD_UNUSED   = 2'd3;
  localparam logic [CFG_ADDR_W-1:0]       PINNED_ADDR  = CFG_ADDR_W'(REG_PINNED) << 2;
  localparam logic [WIN_W-1:0]            SAMPLE_MAX   = {WIN_W{1'b1}};

  // axis ladder, lowest rung first
  localparam logic [AXIS_W-1:0] AXIS_LADDER [RUNGS] = '{
    32'd16000, 32'd64000, 32'd256000, 32'd1000000, 32'd4000000,
    32'd16000000, 32'd64000000, 32'd256000000, 32'd1000000000, 32'd4000000000
  };

  typedef struct {
    logic [CMD_W-1:0]           command;
    logic signed [SAMPLE_W-1:0] sample;
    logic [INDEX_W-1:0]         index;
  } window_req_t;

  typedef struct {
    logic [WIN_W-1:0]   raw_value;
    logic [WIN_W-1:0]   smoothed_value;
    logic [AXIS_W-1:0]  axis_scale;
    logic [TOTAL_W-1:0] sample_number;
    logic [FILL_W-1:0]  fill_count;
  } window_res_t;

  logic clk;
  logic rst_n;

  swa_in_if  in_if ();
  swa_out_if out_if ();

  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  sample_window_autoscale u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_req      (in_if),
    .out_res     (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // requests waiting for the driver, results waiting for the block
  window_req_t request_q [$];
  window_res_t due_result_q [$];

  // predictor state: its own copy of the window, fill, rung, count and mode
  logic [WIN_W-1:0]   win_copy [WINDOW_DEPTH];
  logic [FILL_W-1:0]  held_copy;
  logic [RUNG_W-1:0]  rung_copy;
  logic [TOTAL_W-1:0] total_copy;
  logic               pinned_copy;

  // what the run went through
  int unsigned fail_count;
  int unsigned n_push, n_clamp, n_full_push, n_read, n_read_mid, n_read_beyond;
  int unsigned n_rescale, n_grow, n_shrink, n_pinned_rescale, n_unused, n_checked;

  // generator's view of the fill, used to aim read indices at the edges
  int unsigned gen_fill;

  // driver idling
  int unsigned burst_left;
  int unsigned gap_left;

  // receiver stall pattern
  int unsigned stall_mode;
  int unsigned stall_span;
  logic [31:0] stall_bits;

  // ---------------------------------------------------------------------------
  // clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor: applies one request to the local state, returns its result
  // ---------------------------------------------------------------------------
  function automatic window_res_t predict_window_step(input window_req_t req);
    window_res_t      res;
    logic [WIN_W-1:0] stored;
    logic [63:0]      peak;
    logic [63:0]      cur;
    logic [WIN_W+1:0] sum3;
    int               i;
    int               nxt;

    res.raw_value      = '0;
    res.smoothed_value = '0;
    case (req.command)
      CMD_PUSH: begin
        n_push++;
        // negative samples land as zero
        if (req.sample[SAMPLE_W-1]) begin
          stored = '0;
          n_clamp++;
        end else begin
          stored = req.sample[WIN_W-1:0];
        end
        if (held_copy < WINDOW_DEPTH) begin
          win_copy[held_copy] = stored;
          held_copy++;
        end else begin
          // full: oldest drops out, everything moves one place down
          n_full_push++;
          for (i = 0; i < WINDOW_DEPTH - 1; i++) win_copy[i] = win_copy[i+1];
          win_copy[WINDOW_DEPTH-1] = stored;
        end
        total_copy++;
      end
      CMD_READ: begin
        n_read++;
        if (req.index < held_copy) begin
          res.raw_value = win_copy[req.index];
          // ends of the window and short windows report the entry itself
          if (held_copy < 3 || req.index == 0 || req.index == held_copy - 1) begin
            res.smoothed_value = win_copy[req.index];
          end else begin
            n_read_mid++;
            sum3 = (WIN_W+2)'(win_copy[req.index-1]) + (WIN_W+2)'(win_copy[req.index]) +
                   (WIN_W+2)'(win_copy[req.index+1]);
            res.smoothed_value = WIN_W'(sum3 / 3);
          end
        end else begin
          n_read_beyond++;
        end
      end
      CMD_RESCALE: begin
        n_rescale++;
        if (pinned_copy) begin
          // rung is left where it was
          n_pinned_rescale++;
        end else begin
          peak = '0;
          for (i = 0; i < WINDOW_DEPTH; i++)
            if (i < held_copy && 64'(win_copy[i]) > peak) peak = 64'(win_copy[i]);
          cur = 64'(AXIS_LADDER[rung_copy]);
          if (peak > cur) begin
            // grow: lowest rung above the peak, top rung if none is
            n_grow++;
            nxt = RUNGS - 1;
            for (i = RUNGS - 1; i >= 0; i--)
              if (64'(AXIS_LADDER[i]) > peak) nxt = i;
            rung_copy = RUNG_W'(nxt);
          end else if (3 * peak < cur) begin
            // shrink: highest rung below the axis and above the peak
            n_shrink++;
            nxt = 0;
            for (i = 0; i < RUNGS; i++)
              if (64'(AXIS_LADDER[i]) < cur && 64'(AXIS_LADDER[i]) > peak) nxt = i;
            rung_copy = RUNG_W'(nxt);
          end
        end
      end
      default: begin
        n_unused++;
      end
    endcase

    res.axis_scale    = pinned_copy ? PINNED_AXIS : AXIS_LADDER[rung_copy];
    res.sample_number = total_copy;
    res.fill_count    = held_copy;
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic add_request(input logic [CMD_W-1:0] command,
                             input logic signed [SAMPLE_W-1:0] sample,
                             input logic [INDEX_W-1:0] index);
    window_req_t req;
    req.command = command;
    req.sample  = sample;
    req.index   = index;
    request_q.push_back(req);
    if (command == CMD_PUSH && gen_fill < WINDOW_DEPTH) gen_fill++;
  endtask

  // sample mostly from zero up to the cap, with the odd negative, the odd exact cap and the odd full-range value
  function automatic logic signed [SAMPLE_W-1:0] pick_sample(input logic [63:0] cap);
    logic [63:0] wide;
    wide = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0:       return {1'b1, wide[WIN_W-1:0]};
      1:       return SAMPLE_W'(cap);
      2:       return SAMPLE_W'(wide[WIN_W-1:0]);
      default: return SAMPLE_W'(wide % (cap + 1));
    endcase
  endfunction

  // read index: random or aimed at the ends, the entry before the last and just past the fill
  function automatic logic [INDEX_W-1:0] pick_index();
    case ($urandom_range(0, 7))
      0, 1:    return (gen_fill == 0) ? '0 : INDEX_W'(gen_fill - 1);
      2:       return '0;
      3:       return (gen_fill < WINDOW_DEPTH) ? INDEX_W'(gen_fill) : INDEX_W'($urandom);
      4:       return (gen_fill > 1) ? INDEX_W'(gen_fill - 2) : '1;
      default: return INDEX_W'($urandom_range(0, WINDOW_DEPTH - 1));
    endcase
  endfunction

  // episodes of pushes mostly bounded by a cap, the cap mostly near a ladder boundary, mixed with
  // reads, rescales and the odd unused code
  task automatic queue_random_phase(input int unsigned count);
    int unsigned left;
    int unsigned ep_left;
    int unsigned r;
    int unsigned pick;
    logic [63:0] cap;
    ep_left = 0;
    cap     = 64'(SAMPLE_MAX);
    for (left = count; left != 0; left--) begin
      if (ep_left == 0) begin
        ep_left = $urandom_range(20, 90);
        r = $urandom_range(0, RUNGS - 1);
        case ($urandom_range(0, 6))
          0:       cap = 64'(AXIS_LADDER[r]);
          1:       cap = 64'(AXIS_LADDER[r]) + 1;
          2:       cap = 64'(AXIS_LADDER[r]) - 1;
          3:       cap = 64'(AXIS_LADDER[r]) / 3;
          4:       cap = 64'(AXIS_LADDER[r]) / 3 + 1;
          5:       cap = 64'(SAMPLE_MAX);
          default: cap = 64'($urandom_range(0, 200));
        endcase
      end
      ep_left--;
      pick = $urandom_range(0, 99);
      if (pick < 52)      add_request(CMD_PUSH, pick_sample(cap), INDEX_W'($urandom));
      else if (pick < 76) add_request(CMD_READ, SAMPLE_W'({$urandom, $urandom}), pick_index());
      else if (pick < 95) add_request(CMD_RESCALE, SAMPLE_W'({$urandom, $urandom}),
                                      INDEX_W'($urandom));
      else                add_request(CMD_UNUSED, SAMPLE_W'({$urandom, $urandom}),
                                      INDEX_W'($urandom));
    end
  endtask

  // block is idle once nothing is queued, offered or outstanding
  task automatic wait_idle();
    while (request_q.size() != 0 || in_if.valid || due_result_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // apb write of the pinned mode: setup cycle, then access cycle
  task automatic write_pinned(input logic value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= PINNED_ADDR;
    cfg_pwdata  <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    pinned_copy = value;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n          = 1'b0;
    in_if.valid    = 1'b0;
    in_if.command  = '0;
    in_if.sample   = '0;
    in_if.index    = '0;
    out_if.ready   = 1'b0;
    cfg_psel       = 1'b0;
    cfg_penable    = 1'b0;
    cfg_pwrite     = 1'b0;
    cfg_paddr      = '0;
    cfg_pwdata     = '0;
    fail_count     = 0;
    gen_fill       = 0;
    held_copy      = '0;
    rung_copy      = '0;
    total_copy     = '0;
    pinned_copy    = 1'b0;
    for (int i = 0; i < WINDOW_DEPTH; i++) win_copy[i] = '0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_pinned(1'b0);

    // empty window: reads beyond the fill, rescale with a zero peak, unused code
    add_request(CMD_READ, '0, '0);
    add_request(CMD_READ, '1, '1);
    add_request(CMD_RESCALE, '0, '0);
    add_request(CMD_UNUSED, '1, '1);
    // largest sample, then a negative that clamps to zero
    add_request(CMD_PUSH, SAMPLE_W'(SAMPLE_MAX), '0);
    add_request(CMD_PUSH, -48'sd1, '1);
    // fewer than three held: both entries read back unsmoothed
    add_request(CMD_READ, '0, 6'd0);
    add_request(CMD_READ, '0, 6'd1);
    add_request(CMD_PUSH, {1'b1, {(SAMPLE_W-1){1'b0}}}, '0);
    add_request(CMD_PUSH, 48'sd5, '0);
    // both ends, both middle entries, the first index past the fill and the last index
    add_request(CMD_READ, '0, 6'd0);
    add_request(CMD_READ, '0, 6'd1);
    add_request(CMD_READ, '0, 6'd2);
    add_request(CMD_READ, '0, 6'd3);
    add_request(CMD_READ, '0, 6'd4);
    add_request(CMD_READ, '0, 6'd63);
    // peak beyond the top rung: grows straight to the top and stays there
    add_request(CMD_RESCALE, '0, '0);
    add_request(CMD_RESCALE, '0, '0);
    add_request(CMD_PUSH, 48'sd16000, '0);
    add_request(CMD_PUSH, 48'sd16001, '0);
    add_request(CMD_READ, '0, 6'd4);
    add_request(CMD_UNUSED, '0, '0);
    wait_idle();

    // autoscale, then pinned, then autoscale again from a stale rung
    queue_random_phase(190);
    wait_idle();
    write_pinned(1'b1);
    queue_random_phase(120);
    wait_idle();
    write_pinned(1'b0);
    queue_random_phase(140);
    wait_idle();

    // nothing outstanding; give a stray result time to show up
    repeat (200) @(posedge clk);

    $display("covered %0d results: %0d pushes (%0d clamped, %0d on a full window), %0d reads",
             n_checked, n_push, n_clamp, n_full_push, n_read);
    $display("  %0d smoothed, %0d past fill; %0d rescales (%0d grow, %0d shrink, %0d pinned)",
             n_read_mid, n_read_beyond, n_rescale, n_grow, n_shrink, n_pinned_rescale);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // request driver: bursts of random length separated by random gaps
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : request_driver
    window_req_t nxt;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      burst_left  = $urandom_range(1, 12);
      gap_left    = 0;
    end else if (!in_if.valid || in_if.ready) begin
      // slot is free: previous request taken this edge, or none offered
      if (gap_left != 0) begin
        gap_left--;
        in_if.valid <= 1'b0;
      end else if (request_q.size() != 0) begin
        nxt = request_q.pop_front();
        in_if.valid   <= 1'b1;
        in_if.command <= nxt.command;
        in_if.sample  <= nxt.sample;
        in_if.index   <= nxt.index;
        if (burst_left <= 1) begin
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(16, 40)
                                                   : $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result receiver: always ready, random ready or a rotating stall word, with
  // the mode redrawn whenever a random span runs out, counted in clock cycles
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      stall_mode   = 0;
      stall_span   = 0;
      stall_bits   = '1;
    end else begin
      if (stall_span == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_span = $urandom_range(16, 96);
        stall_bits = $urandom | 32'h0000_0101;
      end else begin
        stall_span--;
      end
      case (stall_mode)
        0:       out_if.ready <= 1'b1;
        1:       out_if.ready <= ($urandom_range(0, 2) != 0);
        default: begin
          stall_bits   = {stall_bits[30:0], stall_bits[31]};
          out_if.ready <= stall_bits[0];
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // scoreboard: predict on each taken request, check each taken result
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    window_req_t taken;
    window_res_t want;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        taken.command = in_if.command;
        taken.sample  = in_if.sample;
        taken.index   = in_if.index;
        due_result_q.push_back(predict_window_step(taken));
      end
      if (out_if.valid && out_if.ready) begin
        if (due_result_q.size() == 0) begin
          $error("result arrived with no request outstanding");
          fail_count++;
        end else begin
          want = due_result_q.pop_front();
          n_checked++;
          check_field("raw_value", 64'(want.raw_value), 64'(out_if.raw_value));
          check_field("smoothed_value", 64'(want.smoothed_value),
                      64'(out_if.smoothed_value));
          check_field("axis_scale", 64'(want.axis_scale), 64'(out_if.axis_scale));
          check_field("sample_number", 64'(want.sample_number),
                      64'(out_if.sample_number));
          check_field("fill_count", 64'(want.fill_count), 64'(out_if.fill_count));
        end
      end
    end
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/swa_pkg.sv
hw/rtl/swa_in_if.sv
hw/rtl/swa_out_if.sv
hw/rtl/swa_cell.sv
hw/rtl/swa_chain.sv
hw/rtl/swa_div3.sv
hw/rtl/sample_window_autoscale.sv
verif/tb_top.sv
